/* rtl/tcce_pkg.sv */
// Shared types and constants for the text console cursor engine.
// No dependencies; every other file of the block but tcce_ram imports this package.
package tcce_pkg;

    localparam int ROWS   = 25;
    localparam int COLS   = 80;
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);

    localparam int CMD_W   = 2;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int POS_W   = 11;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int CELL_W  = CHAR_W + 2 * COLOR_W;

    localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0]  CH_BLANK     = 8'd32;
    localparam logic [COLOR_W-1:0] COLOR_RESET  = 4'd7;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RDATA,
        ST_COPY,
        ST_BOTTOM,
        ST_CLEAR,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ZERO_FILL,
        OP_BLANK_FILL,
        OP_COPY,
        OP_BOTTOM_FILL,
        OP_READ,
        OP_PUT
    } dp_op_t;

    typedef struct packed {
        logic   take;
        logic   cnt_clr;
        logic   cnt_scroll;
        dp_op_t op;
        logic   out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic in_valid;
        cmd_t cmd;
        logic is_newline;
        logic need_scroll;
        logic cnt_last;
        logic cnt_end;
        logic out_free;
    } dp_status_t;

    // Linear cell address of a row and column.
    function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        cell_index = ADDR_W'(32'(row) * 32'(COLS) + 32'(col));
    endfunction

endpackage

/* rtl/tcce_if.sv */
// Valid/ready channel interfaces for the command and response transactions.
// Depends on tcce_pkg for the field widths.
interface tcce_cmd_if import tcce_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [CHAR_W-1:0]    char_code;
    logic [COLOR_W-1:0]   fore_color;
    logic [COLOR_W-1:0]   back_color;
    logic [ROW_W-1:0]     read_row;
    logic [COL_W-1:0]     read_column;

    modport source (
        output valid, command, char_code, fore_color, back_color, read_row, read_column,
        input  ready
    );
    modport sink (
        input  valid, command, char_code, fore_color, back_color, read_row, read_column,
        output ready
    );
endinterface

interface tcce_rsp_if import tcce_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [ROW_W-1:0]     cursor_row;
    logic [COL_W-1:0]     cursor_column;
    logic [POS_W-1:0]     cursor_position;
    logic [CHAR_W-1:0]    cell_char;
    logic [COLOR_W-1:0]   cell_fore;
    logic [COLOR_W-1:0]   cell_back;

    modport source (
        output valid, cursor_row, cursor_column, cursor_position, cell_char, cell_fore,
               cell_back,
        input  ready
    );
    modport sink (
        input  valid, cursor_row, cursor_column, cursor_position, cell_char, cell_fore,
               cell_back,
        output ready
    );
endinterface

/* rtl/tcce_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [WIDTH-1:0]             wdata,
    input  logic                         re,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [WIDTH-1:0]             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tcce_ctrl.sv */
// Sequencer of the console engine: decides which datapath operation runs each cycle.
// Depends on tcce_pkg for the state, operation, command and status types.
module tcce_ctrl import tcce_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t sts,
    output ctl_cmd_t   ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (sts.cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (sts.in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.need_scroll)
                begin
                    state_next = ST_COPY;
                end
                else if (sts.cmd == CMD_CLEAR)
                begin
                    state_next = ST_CLEAR;
                end
                else if (sts.cmd == CMD_READ)
                begin
                    state_next = ST_RDATA;
                end
                else
                begin
                    state_next = sts.out_free ? ST_IDLE : ST_FINISH;
                end
            end
            ST_COPY:
            begin
                if (sts.cnt_end)
                begin
                    state_next = ST_BOTTOM;
                end
            end
            ST_BOTTOM:
            begin
                // A newline is finished once the screen has moved up; any other
                // character still has to be placed on the fresh bottom row.
                if (sts.cnt_last)
                begin
                    if (!sts.is_newline)
                    begin
                        state_next = ST_EXEC;
                    end
                    else
                    begin
                        state_next = sts.out_free ? ST_IDLE : ST_FINISH;
                    end
                end
            end
            ST_CLEAR:
            begin
                if (sts.cnt_last)
                begin
                    state_next = sts.out_free ? ST_IDLE : ST_FINISH;
                end
            end
            ST_RDATA, ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        ctl = '{take: 1'b0, cnt_clr: 1'b0, cnt_scroll: 1'b0, op: OP_NONE, out_load: 1'b0};
        unique case (state_reg)
            ST_INIT:
            begin
                ctl.op = OP_ZERO_FILL;
            end
            ST_IDLE:
            begin
                ctl.take = 1'b1;
            end
            ST_EXEC:
            begin
                if (sts.need_scroll)
                begin
                    ctl.cnt_scroll = 1'b1;
                end
                else if (sts.cmd == CMD_CLEAR)
                begin
                    ctl.cnt_clr = 1'b1;
                end
                else if (sts.cmd == CMD_READ)
                begin
                    ctl.op = OP_READ;
                end
                else
                begin
                    ctl.op       = OP_PUT;
                    ctl.out_load = sts.out_free;
                end
            end
            ST_COPY:
            begin
                ctl.op = OP_COPY;
            end
            ST_BOTTOM:
            begin
                ctl.op       = OP_BOTTOM_FILL;
                ctl.out_load = sts.cnt_last && sts.is_newline && sts.out_free;
            end
            ST_CLEAR:
            begin
                ctl.op       = OP_BLANK_FILL;
                ctl.out_load = sts.cnt_last && sts.out_free;
            end
            ST_RDATA, ST_FINISH:
            begin
                ctl.out_load = sts.out_free;
            end
            default:
            begin
                ctl.op = OP_NONE;
            end
        endcase
    end

endmodule

/* rtl/tcce_dpath.sv */
// Datapath of the console engine: cursor, sweep counter, cell store and result register.
// Depends on tcce_pkg, the channel interfaces and tcce_ram.
module tcce_dpath import tcce_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    tcce_cmd_if.sink            cmd_ch,
    tcce_rsp_if.source          rsp_ch,
    input  logic                cfg_wr_en,
    input  logic [COLOR_W-1:0]  cfg_wr_data,
    input  ctl_cmd_t            ctl,
    output dp_status_t          sts
);

    localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL   = COL_W'(COLS - 1);
    localparam logic [COL_W-1:0] BS_COL     = COL_W'(COLS - 2);
    localparam logic [CNT_W-1:0] CNT_COLS   = CNT_W'(COLS);
    localparam logic [CNT_W-1:0] CNT_BOTTOM = CNT_W'(CELLS - COLS);
    localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(CELLS - 1);
    localparam logic [CNT_W-1:0] CNT_END    = CNT_W'(CELLS);
    localparam logic [CNT_W-1:0] COPY_LAG   = CNT_W'(COLS + 1);
    localparam logic [POS_W-1:0] POS_BOTTOM = POS_W'((ROWS - 1) * COLS);

    // Transaction being worked on.
    cmd_t               cmd_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [COLOR_W-1:0] fore_reg;
    logic [COLOR_W-1:0] back_reg;
    logic [ROW_W-1:0]   rrow_reg;
    logic [COL_W-1:0]   rcol_reg;

    logic [COLOR_W-1:0] color_reg;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               hit_reg, hit_next;

    logic               out_valid_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [POS_W-1:0]   out_pos_reg;
    logic [CELL_W-1:0]  out_cell_reg;

    logic               accept;
    logic               is_newline, is_bs;
    logic               at_last_row, at_last_col;
    logic [ROW_W-1:0]   wrap_row, bs_row, tgt_row;
    logic [COL_W-1:0]   wrap_col, bs_col, tgt_col;
    logic               bs_home;
    logic [ADDR_W-1:0]  tgt_addr;
    logic               read_hit;
    logic [CELL_W-1:0]  cell_out;

    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [CELL_W-1:0]  ram_wdata, ram_rdata;

    assign accept       = ctl.take && cmd_ch.valid;
    assign cmd_ch.ready = ctl.take;

    assign is_newline  = (char_reg == CH_NEWLINE);
    assign is_bs       = (char_reg == CH_BACKSPACE);
    assign at_last_row = (row_reg == LAST_ROW);
    assign at_last_col = (col_reg == LAST_COL);

    // Wrap to the next row first, then step back for a backspace.
    assign wrap_row = at_last_col ? ROW_W'(row_reg + 1'b1) : row_reg;
    assign wrap_col = at_last_col ? '0 : col_reg;
    assign bs_home  = (wrap_row == '0) && (wrap_col == '0);
    assign bs_row   = (wrap_col == '0) ? ROW_W'(wrap_row - 1'b1) : wrap_row;
    assign bs_col   = (wrap_col == '0) ? BS_COL : COL_W'(wrap_col - 1'b1);
    assign tgt_row  = is_bs ? bs_row : wrap_row;
    assign tgt_col  = is_bs ? bs_col : wrap_col;
    assign tgt_addr = cell_index(tgt_row, tgt_col);

    assign read_hit = (32'(rrow_reg) < ROWS) && (32'(rcol_reg) < COLS);
    assign cell_out = hit_reg ? ram_rdata : '0;

    assign sts.in_valid    = cmd_ch.valid;
    assign sts.cmd         = cmd_reg;
    assign sts.is_newline  = is_newline;
    assign sts.need_scroll = (cmd_reg == CMD_PUT)
                             && (is_newline ? (row_reg >= LAST_ROW)
                                            : (at_last_row && at_last_col));
    assign sts.cnt_last    = (cnt_reg == CNT_LAST);
    assign sts.cnt_end     = (cnt_reg == CNT_END);
    assign sts.out_free    = !out_valid_reg || rsp_ch.ready;

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        pos_next  = pos_reg;
        cnt_next  = cnt_reg;
        hit_next  = hit_reg;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = cnt_reg[ADDR_W-1:0];
        ram_raddr = cnt_reg[ADDR_W-1:0];
        ram_wdata = '0;

        if (accept)
        begin
            hit_next = 1'b0;
        end
        if (ctl.cnt_clr)
        begin
            cnt_next = '0;
        end
        if (ctl.cnt_scroll)
        begin
            cnt_next = CNT_COLS;
        end

        unique case (ctl.op)
            OP_NONE:
            begin
                ram_we = 1'b0;
            end
            OP_ZERO_FILL:
            begin
                ram_we   = 1'b1;
                cnt_next = CNT_W'(cnt_reg + 1'b1);
            end
            OP_BLANK_FILL:
            begin
                ram_we    = 1'b1;
                ram_wdata = {CH_BLANK, color_reg, back_reg};
                cnt_next  = CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == CNT_LAST)
                begin
                    row_next = '0;
                    col_next = '0;
                    pos_next = '0;
                end
            end
            OP_COPY:
            begin
                // The read runs one row ahead; its registered data is written in the next cycle.
                ram_re    = (cnt_reg < CNT_END);
                ram_we    = (cnt_reg > CNT_COLS);
                ram_waddr = ADDR_W'(cnt_reg - COPY_LAG);
                ram_wdata = ram_rdata;
                cnt_next  = (cnt_reg == CNT_END) ? CNT_BOTTOM : CNT_W'(cnt_reg + 1'b1);
            end
            OP_BOTTOM_FILL:
            begin
                ram_we    = 1'b1;
                ram_wdata = {CH_BLANK, color_reg, {COLOR_W{1'b0}}};
                cnt_next  = CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == CNT_LAST)
                begin
                    row_next = LAST_ROW;
                    col_next = '0;
                    pos_next = is_newline ? POS_BOTTOM : POS_W'(POS_BOTTOM + 1'b1);
                end
            end
            OP_READ:
            begin
                hit_next  = read_hit;
                ram_re    = read_hit;
                ram_raddr = cell_index(rrow_reg, rcol_reg);
            end
            OP_PUT:
            begin
                if (cmd_reg == CMD_PUT)
                begin
                    if (is_newline)
                    begin
                        row_next = ROW_W'(row_reg + 1'b1);
                        col_next = '0;
                        pos_next = POS_W'(cell_index(ROW_W'(row_reg + 1'b1), '0));
                    end
                    else if (!(is_bs && bs_home))
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = tgt_addr;
                        ram_wdata = {(is_bs ? CH_BLANK : char_reg), fore_reg, back_reg};
                        row_next  = tgt_row;
                        col_next  = is_bs ? tgt_col : COL_W'(tgt_col + 1'b1);
                        pos_next  = POS_W'(POS_W'(tgt_addr) + 1'b1);
                    end
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg     <= COLOR_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                color_reg <= cfg_wr_data;
            end
            row_reg <= row_next;
            col_reg <= col_next;
            pos_reg <= pos_next;
            cnt_reg <= cnt_next;
            hit_reg <= hit_next;
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd_t'(cmd_ch.command);
            char_reg <= cmd_ch.char_code;
            fore_reg <= cmd_ch.fore_color;
            back_reg <= cmd_ch.back_color;
            rrow_reg <= cmd_ch.read_row;
            rcol_reg <= cmd_ch.read_column;
        end
        if (ctl.out_load)
        begin
            out_row_reg  <= row_next;
            out_col_reg  <= col_next;
            out_pos_reg  <= pos_next;
            out_cell_reg <= cell_out;
        end
    end

    assign rsp_ch.valid           = out_valid_reg;
    assign rsp_ch.cursor_row      = out_row_reg;
    assign rsp_ch.cursor_column   = out_col_reg;
    assign rsp_ch.cursor_position = out_pos_reg;
    assign rsp_ch.cell_char       = out_cell_reg[CELL_W-1 -: CHAR_W];
    assign rsp_ch.cell_fore       = out_cell_reg[2*COLOR_W-1 -: COLOR_W];
    assign rsp_ch.cell_back       = out_cell_reg[COLOR_W-1:0];

    tcce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

/* rtl/text_console_cursor_engine.sv */
// Top level of the text console cursor engine: joins the sequencer and the datapath.
// Depends on tcce_pkg, tcce_if, tcce_ctrl and tcce_dpath.
//
//   channel   | dir | handshake            | carries
//   ----------+-----+----------------------+-------------------------------------------
//   cmd_ch    | in  | valid/ready          | command, char_code, colors, read row/column
//   rsp_ch    | out | valid/ready          | cursor row/column/position, cell fields
//   cfg       | in  | cfg_wr_en, no ready  | default_text_color
//
// Put character and command 3 pass through the execute state alone, and a read adds
// the read-data state. A newline that scrolls runs the row copy, then the bottom row
// fill, and any other character that scrolls is then placed on the fresh bottom row
// in the execute state; clear sweeps the whole store, one cell written per cycle.
// After reset the store is swept to zero with cmd_ch.ready low.
// A finished result waits in the output register while the next command is taken;
// a second result waits in the engine until rsp_ch frees the register.
module text_console_cursor_engine import tcce_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    tcce_cmd_if.sink           cmd_ch,
    tcce_rsp_if.source         rsp_ch,
    input  logic               cfg_wr_en,
    input  logic [COLOR_W-1:0] cfg_wr_data
);

    ctl_cmd_t   ctl;
    dp_status_t sts;

    tcce_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctl   (ctl)
    );

    tcce_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_ch      (cmd_ch),
        .rsp_ch      (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ctl         (ctl),
        .sts         (sts)
    );

endmodule

/* rtl/tcce_checker.sv */
// Port-level assertions for the text console cursor engine, bound to the top level.
// Depends on tcce_pkg and text_console_cursor_engine.
module tcce_checker import tcce_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [ROW_W-1:0]   rsp_row,
    input logic [COL_W-1:0]   rsp_col,
    input logic [POS_W-1:0]   rsp_pos,
    input logic [CHAR_W-1:0]  rsp_char
);

    logic [12:0] lin_pos;

    assign lin_pos = 13'(13'(rsp_row) * 13'(COLS) + 13'(rsp_col));

    // One command is worked on at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while the previous one was still running");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos) && $stable(rsp_char))
        else $error("stalled response transaction changed");

    a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp_row) < ROWS) && (32'(rsp_col) < COLS))
        else $error("cursor outside the screen");

    // The hardware cursor sits on the cursor cell or just after it.
    a_pos_follows: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (13'(rsp_pos) == lin_pos) || (13'(rsp_pos) == 13'(lin_pos + 1'b1)))
        else $error("hardware cursor position out of step with the cursor");

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_ch.valid),
    .cmd_ready (cmd_ch.ready),
    .rsp_valid (rsp_ch.valid),
    .rsp_ready (rsp_ch.ready),
    .rsp_row   (rsp_ch.cursor_row),
    .rsp_col   (rsp_ch.cursor_column),
    .rsp_pos   (rsp_ch.cursor_position),
    .rsp_char  (rsp_ch.cell_char)
);
